// ===== sv/cpualu_pkg.sv =====
package cpualu_pkg;

  typedef enum logic [4:0] {
    OP_ADD      = 5'd0,
    OP_ADC      = 5'd1,
    OP_SUB      = 5'd2,
    OP_SBC      = 5'd3,
    OP_CMP      = 5'd4,
    OP_AND      = 5'd5,
    OP_OR       = 5'd6,
    OP_XOR      = 5'd7,
    OP_NOT      = 5'd8,
    OP_SRL      = 5'd9,
    OP_SL       = 5'd10,
    OP_SRA      = 5'd11,
    OP_RR       = 5'd12,
    OP_RL       = 5'd13,
    OP_SWAP     = 5'd14,
    OP_SWAPH    = 5'd15,
    OP_MLTH     = 5'd16,
    OP_MLTUH    = 5'd17,
    OP_MLTW     = 5'd18,
    OP_MLTUW    = 5'd19,
    OP_COND     = 5'd20,
    OP_SETFLAGS = 5'd21,
    OP_GETFLAGS = 5'd22
  } op_e;

  localparam logic [3:0] COND_GT  = 4'd4;
  localparam logic [3:0] COND_GE  = 4'd5;
  localparam logic [3:0] COND_LT  = 4'd6;
  localparam logic [3:0] COND_LE  = 4'd7;
  localparam logic [3:0] COND_UGT = 4'd8;
  localparam logic [3:0] COND_UGE = 4'd9;
  localparam logic [3:0] COND_ULT = 4'd10;
  localparam logic [3:0] COND_ULE = 4'd11;
  localparam logic [3:0] COND_EQ  = 4'd12;
  localparam logic [3:0] COND_NE  = 4'd13;

  localparam int unsigned DataW = 32;
  localparam int unsigned ShamtW = 5;

  // Packed in the flag word order: bit3 C, bit2 V, bit1 Z, bit0 N.
  typedef struct packed {
    logic c;
    logic v;
    logic z;
    logic n;
  } flags_t;

  typedef struct packed {
    logic [4:0]       op;
    logic [DataW-1:0] operand_a;
    logic [DataW-1:0] operand_b;
    logic [3:0]       condition;
  } in_t;

  typedef struct packed {
    logic [DataW-1:0] result;
    logic [DataW-1:0] result_high;
    logic [3:0]       flags_out;
    logic             condition_true;
  } out_t;

endpackage

// ===== sv/cpualu_exec.sv =====
module cpualu_exec (
  input  cpualu_pkg::in_t    item_i,
  input  cpualu_pkg::flags_t flags_i,
  output cpualu_pkg::out_t   res_o
);

  logic [cpualu_pkg::DataW-1:0]   a, b, b_eff, sum, r, hi;
  logic [cpualu_pkg::ShamtW-1:0]  shamt;
  logic                           is_sub, cin, cout;
  logic [2*cpualu_pkg::DataW-1:0] rot_r, rot_l;
  logic signed [cpualu_pkg::DataW:0]     mul_a, mul_b;
  logic signed [2*cpualu_pkg::DataW+1:0] prod;
  cpualu_pkg::flags_t             nf;
  cpualu_pkg::op_e                op;
  logic                           ct;

  assign op    = cpualu_pkg::op_e'(item_i.op);
  assign a     = item_i.operand_a;
  assign b     = item_i.operand_b;
  assign shamt = b[cpualu_pkg::ShamtW-1:0];

  // Shared adder: subtract as a + ~b + 1, borrow-in folds into the carry-in.
  always_comb begin
    is_sub = 1'b0;
    cin    = 1'b0;
    unique case (op)
      cpualu_pkg::OP_ADC: cin = flags_i.c;
      cpualu_pkg::OP_SUB, cpualu_pkg::OP_CMP: begin
        is_sub = 1'b1;
        cin    = 1'b1;
      end
      cpualu_pkg::OP_SBC: begin
        is_sub = 1'b1;
        cin    = ~flags_i.c;
      end
      default: ;
    endcase
  end

  assign b_eff       = is_sub ? ~b : b;
  assign {cout, sum} = {1'b0, a} + {1'b0, b_eff} + {{cpualu_pkg::DataW{1'b0}}, cin};

  assign rot_r = {a, a} >> shamt;
  assign rot_l = {a, a} << shamt;

  // One 33x33 signed multiplier covers all four multiply flavors.
  always_comb begin
    unique case (op)
      cpualu_pkg::OP_MLTH: begin
        mul_a = {{17{a[15]}}, a[15:0]};
        mul_b = {{17{b[15]}}, b[15:0]};
      end
      cpualu_pkg::OP_MLTUH: begin
        mul_a = {17'd0, a[15:0]};
        mul_b = {17'd0, b[15:0]};
      end
      cpualu_pkg::OP_MLTW: begin
        mul_a = {a[31], a};
        mul_b = {b[31], b};
      end
      default: begin
        mul_a = {1'b0, a};
        mul_b = {1'b0, b};
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    r  = '0;
    hi = '0;
    nf = flags_i;
    unique case (op)
      cpualu_pkg::OP_ADD, cpualu_pkg::OP_ADC: begin
        r    = sum;
        nf.v = ~(a[31] ^ b_eff[31]) & (a[31] ^ sum[31]);
        nf.c = cout;
        nf.n = sum[31];
        nf.z = (sum == '0);
      end
      cpualu_pkg::OP_SUB, cpualu_pkg::OP_SBC, cpualu_pkg::OP_CMP: begin
        r    = sum;
        nf.v = ~(a[31] ^ b_eff[31]) & (a[31] ^ sum[31]);
        nf.c = ~cout;
        nf.n = sum[31];
        nf.z = (sum == '0);
      end
      cpualu_pkg::OP_AND, cpualu_pkg::OP_OR, cpualu_pkg::OP_XOR,
      cpualu_pkg::OP_NOT: begin
        unique case (op)
          cpualu_pkg::OP_AND: r = a & b;
          cpualu_pkg::OP_OR:  r = a | b;
          cpualu_pkg::OP_XOR: r = a ^ b;
          default:            r = ~b;
        endcase
        nf.v = 1'b0;
        nf.n = r[31];
        nf.z = (r == '0);
      end
      cpualu_pkg::OP_SRL, cpualu_pkg::OP_SL, cpualu_pkg::OP_SRA,
      cpualu_pkg::OP_RR, cpualu_pkg::OP_RL: begin
        unique case (op)
          cpualu_pkg::OP_SRL: r = a >> shamt;
          cpualu_pkg::OP_SL:  r = a << shamt;
          cpualu_pkg::OP_SRA: r = $unsigned($signed(a) >>> shamt);
          cpualu_pkg::OP_RR:  r = rot_r[cpualu_pkg::DataW-1:0];
          default:            r = rot_l[2*cpualu_pkg::DataW-1:cpualu_pkg::DataW];
        endcase
        nf.n = r[31];
        nf.z = (r == '0);
      end
      cpualu_pkg::OP_SWAP:  r = {b[7:0], b[15:8], b[23:16], b[31:24]};
      cpualu_pkg::OP_SWAPH: r = {b[23:16], b[31:24], b[7:0], b[15:8]};
      cpualu_pkg::OP_MLTH, cpualu_pkg::OP_MLTUH: r = prod[cpualu_pkg::DataW-1:0];
      cpualu_pkg::OP_MLTW, cpualu_pkg::OP_MLTUW: begin
        r  = prod[cpualu_pkg::DataW-1:0];
        hi = prod[2*cpualu_pkg::DataW-1:cpualu_pkg::DataW];
      end
      cpualu_pkg::OP_SETFLAGS: begin
        nf = cpualu_pkg::flags_t'(a[3:0]);
        r  = {28'd0, a[3:0]};
      end
      cpualu_pkg::OP_GETFLAGS: r = {28'd0, flags_i};
      default: ;
    endcase
  end

  // Test the condition on the flags as they stand after this op.
  always_comb begin
    unique case (item_i.condition)
      cpualu_pkg::COND_GT:  ct = ~nf.z & (nf.n == nf.v);
      cpualu_pkg::COND_GE:  ct = (nf.n == nf.v);
      cpualu_pkg::COND_LT:  ct = (nf.n != nf.v);
      cpualu_pkg::COND_LE:  ct = nf.z | (nf.n != nf.v);
      cpualu_pkg::COND_UGT: ct = ~nf.z & ~nf.c;
      cpualu_pkg::COND_UGE: ct = ~nf.c;
      cpualu_pkg::COND_ULT: ct = nf.c;
      cpualu_pkg::COND_ULE: ct = nf.z | nf.c;
      cpualu_pkg::COND_EQ:  ct = nf.z;
      cpualu_pkg::COND_NE:  ct = ~nf.z;
      default:              ct = 1'b1;
    endcase
  end

  assign res_o.result         = r;
  assign res_o.result_high    = hi;
  assign res_o.flags_out      = nf;
  assign res_o.condition_true = ct;

endmodule

// ===== sv/cpu_alu_with_flags.sv =====
// 32-bit integer ALU with N, Z, V, C flags.
//
// Input channel (in_valid_i / in_ready_o / in_data_i) carries one operation:
// op code, two 32-bit operands and a branch condition code. Output channel
// (out_valid_o / out_ready_i / out_data_o) returns one transaction per input:
// result, high product word, the flags after the op and the condition test.
//
// An input accepted into the input register moves on into the result
// register whenever that register is free or draining, and is presented
// on the output from there. Throughput is one transaction per cycle while
// the receiver does not stall, set by the single pass of the execute logic
// (the 33x33 multiplier is the longest path) between the two registers.
// The flag register is updated as a transaction moves into the result
// register, so the next operation sees the new flags without a bubble.
//
// Reset clears both valid bits and the flags to zero. When the receiver
// stalls, the result register holds; the input register still takes one
// more transaction, after which in_ready_o drops until the output drains.
module cpu_alu_with_flags (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cpualu_pkg::in_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output cpualu_pkg::out_t out_data_o
);

  logic               s1_valid_q, s1_valid_d;
  cpualu_pkg::in_t    s1_q;
  logic               out_valid_q, out_valid_d;
  cpualu_pkg::out_t   out_q;
  cpualu_pkg::flags_t flags_q, flags_d;
  cpualu_pkg::out_t   exec_res;
  logic               s1_adv, s1_fire, in_fire;

  // Advance the execute stage whenever the result register is free or draining.
  assign s1_adv     = ~out_valid_q | out_ready_i;
  assign s1_fire    = s1_valid_q & s1_adv;
  assign in_ready_o = ~s1_valid_q | s1_adv;
  assign in_fire    = in_valid_i & in_ready_o;

  cpualu_exec u_exec (
    .item_i  (s1_q),
    .flags_i (flags_q),
    .res_o   (exec_res)
  );

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    flags_d     = flags_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
    if (s1_fire) begin
      out_valid_d = 1'b1;
      flags_d     = cpualu_pkg::flags_t'(exec_res.flags_out);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Hold control state under reset; payload needs none.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      flags_q     <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_data_i;
    end
    if (s1_fire) begin
      out_q <= exec_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The reported flags always match the flag register while a result waits.
  a_flags_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.flags_out == flags_q))
    else $error("result flags differ from flag register");

  // Flags move only when a transaction leaves the execute stage.
  a_flags_still : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(flags_q))
    else $error("flags changed without a transaction");

  // Load flags from operand_a on setflags.
  a_setflags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && (s1_q.op == cpualu_pkg::OP_SETFLAGS))
      |=> (flags_q == $past(s1_q.operand_a[3:0])))
    else $error("setflags did not load the flags");

  // Swaps, word multiplies, cond and getflags leave the flags alone.
  a_flags_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && ((s1_q.op == cpualu_pkg::OP_SWAP) || (s1_q.op == cpualu_pkg::OP_SWAPH)
      || (s1_q.op == cpualu_pkg::OP_MLTW) || (s1_q.op == cpualu_pkg::OP_MLTUW)
      || (s1_q.op == cpualu_pkg::OP_COND) || (s1_q.op == cpualu_pkg::OP_GETFLAGS)))
      |=> $stable(flags_q))
    else $error("flags changed by a flag-neutral op");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the 32-bit flag ALU. A queue of operations is built
// up front (a directed set of corner cases, then random traffic), a clocked
// driver offers them on the input channel, and every accepted transaction is
// run through a local model of the ALU and its flag register. A clocked
// monitor pops the oldest prediction for every result transaction and checks
// it field by field.
module tb_top;

  // Op codes past OP_GETFLAGS do nothing in the ALU.
  localparam logic [4:0] OP_UNUSED_MIN = 5'd23;
  localparam logic [4:0] OP_UNUSED_MAX = 5'd31;
  // Condition codes outside the branch set always hold.
  localparam logic [3:0] COND_ALWAYS_LO = 4'd0;
  localparam logic [3:0] COND_ALWAYS_HI = 4'd15;

  localparam int unsigned RandomOps  = 1250;
  localparam int unsigned PhaseLen   = 100;
  localparam int unsigned HoldAt     = 50;
  localparam int unsigned HoldCycles = 150;
  localparam int unsigned DrainWait  = 10;
  localparam int unsigned CycleLimit = 100000;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             out_ready_i = 1'b0;
  cpualu_pkg::in_t  in_data_i   = '0;
  logic             in_ready_o;
  logic             out_valid_o;
  cpualu_pkg::out_t out_data_o;

  cpualu_pkg::in_t    op_queue[$];      // operations still to be offered
  cpualu_pkg::out_t   result_queue[$];  // predicted results, oldest first
  cpualu_pkg::flags_t alu_flags = '0;   // model copy of the N, Z, V, C register
  cpualu_pkg::out_t   expected_item;

  int unsigned n_accepted = 0;
  int unsigned n_errors   = 0;
  int unsigned hold_left  = 0;
  bit          hold_done  = 1'b0;
  int unsigned cycle_count = 0;

  cpu_alu_with_flags uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Execute one operation against the model flags, update them, and return
  // the result transaction the ALU must produce.
  function automatic cpualu_pkg::out_t alu_execute(input cpualu_pkg::in_t op_in);
    logic [31:0]        a, b, r, hi;
    logic [4:0]         sh;
    logic [32:0]        wide;
    logic [63:0]        rot;
    logic [63:0]        prod;
    logic signed [31:0] sa16, sb16;
    logic signed [63:0] sa64, sb64;
    logic               cin;
    logic               cond_ok;
    cpualu_pkg::flags_t f;
    cpualu_pkg::out_t   res;
    a  = op_in.operand_a;
    b  = op_in.operand_b;
    sh = b[4:0];
    r  = '0;
    hi = '0;
    f  = alu_flags;
    case (op_in.op)
      cpualu_pkg::OP_ADD, cpualu_pkg::OP_ADC: begin
        cin  = (op_in.op == cpualu_pkg::OP_ADC) ? f.c : 1'b0;
        wide = {1'b0, a} + {1'b0, b} + {32'd0, cin};
        r    = wide[31:0];
        f.v  = ~(a[31] ^ b[31]) & (a[31] ^ r[31]);
        f.c  = wide[32];
        f.n  = r[31];
        f.z  = (r == '0);
      end
      cpualu_pkg::OP_SUB, cpualu_pkg::OP_SBC, cpualu_pkg::OP_CMP: begin
        // Carry holds the borrow: set when a < b + borrow-in.
        cin  = (op_in.op == cpualu_pkg::OP_SBC) ? f.c : 1'b0;
        r    = a - b - {31'd0, cin};
        wide = {1'b0, b} + {32'd0, cin};
        f.v  = (a[31] ^ b[31]) & (a[31] ^ r[31]);
        f.c  = ({1'b0, a} < wide);
        f.n  = r[31];
        f.z  = (r == '0);
      end
      cpualu_pkg::OP_AND, cpualu_pkg::OP_OR, cpualu_pkg::OP_XOR,
      cpualu_pkg::OP_NOT: begin
        case (op_in.op)
          cpualu_pkg::OP_AND: r = a & b;
          cpualu_pkg::OP_OR:  r = a | b;
          cpualu_pkg::OP_XOR: r = a ^ b;
          default:            r = ~b;
        endcase
        f.v = 1'b0;
        f.n = r[31];
        f.z = (r == '0);
      end
      cpualu_pkg::OP_SRL, cpualu_pkg::OP_SL, cpualu_pkg::OP_SRA,
      cpualu_pkg::OP_RR, cpualu_pkg::OP_RL: begin
        // Shifts and rotates touch only N and Z.
        case (op_in.op)
          cpualu_pkg::OP_SRL: r = a >> sh;
          cpualu_pkg::OP_SL:  r = a << sh;
          cpualu_pkg::OP_SRA: r = $signed(a) >>> sh;
          cpualu_pkg::OP_RR: begin
            rot = {a, a} >> sh;
            r   = rot[31:0];
          end
          default: begin
            rot = {a, a} << sh;
            r   = rot[63:32];
          end
        endcase
        f.n = r[31];
        f.z = (r == '0);
      end
      cpualu_pkg::OP_SWAP:  r = {b[7:0], b[15:8], b[23:16], b[31:24]};
      cpualu_pkg::OP_SWAPH: r = {b[23:16], b[31:24], b[7:0], b[15:8]};
      cpualu_pkg::OP_MLTH: begin
        sa16 = {{16{a[15]}}, a[15:0]};
        sb16 = {{16{b[15]}}, b[15:0]};
        r    = sa16 * sb16;
      end
      cpualu_pkg::OP_MLTUH: r = {16'd0, a[15:0]} * {16'd0, b[15:0]};
      cpualu_pkg::OP_MLTW: begin
        sa64 = {{32{a[31]}}, a};
        sb64 = {{32{b[31]}}, b};
        prod = sa64 * sb64;
        r    = prod[31:0];
        hi   = prod[63:32];
      end
      cpualu_pkg::OP_MLTUW: begin
        prod = {32'd0, a} * {32'd0, b};
        r    = prod[31:0];
        hi   = prod[63:32];
      end
      cpualu_pkg::OP_SETFLAGS: begin
        f = a[3:0];
        r = {28'd0, f};
      end
      cpualu_pkg::OP_GETFLAGS: r = {28'd0, f};
      default: ;  // cond and unused codes leave everything alone
    endcase

    // Test the condition on the flags after the op.
    case (op_in.condition)
      cpualu_pkg::COND_GT:  cond_ok = !f.z && (f.n == f.v);
      cpualu_pkg::COND_GE:  cond_ok = (f.n == f.v);
      cpualu_pkg::COND_LT:  cond_ok = (f.n != f.v);
      cpualu_pkg::COND_LE:  cond_ok = f.z || (f.n != f.v);
      cpualu_pkg::COND_UGT: cond_ok = !f.z && !f.c;
      cpualu_pkg::COND_UGE: cond_ok = !f.c;
      cpualu_pkg::COND_ULT: cond_ok = f.c;
      cpualu_pkg::COND_ULE: cond_ok = f.z || f.c;
      cpualu_pkg::COND_EQ:  cond_ok = f.z;
      cpualu_pkg::COND_NE:  cond_ok = !f.z;
      default:              cond_ok = 1'b1;
    endcase

    alu_flags          = f;
    res.result         = r;
    res.result_high    = hi;
    res.flags_out      = f;
    res.condition_true = cond_ok;
    return res;
  endfunction

  // Idle chance in percent for one side, stepped through four phases as
  // transactions go by: none, sender only, receiver only, both.
  function automatic int unsigned idle_pct(input bit receiver);
    int unsigned phase;
    phase = (n_accepted / PhaseLen) % 4;
    case (phase)
      1:       return receiver ? 0 : 66;
      2:       return receiver ? 66 : 0;
      3:       return 31;
      default: return 0;
    endcase
  endfunction

  // Bias operands toward the values that hit carry, overflow and zero.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_op(input logic [4:0] op, input logic [31:0] a, input logic [31:0] b,
                         input logic [3:0] cond);
    cpualu_pkg::in_t item;
    item.op        = op;
    item.operand_a = a;
    item.operand_b = b;
    item.condition = cond;
    op_queue.push_back(item);
  endtask

  // Driver: record each accepted transaction against the model, then hold the
  // current one or advance to the next queued operation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        result_queue.push_back(alu_execute(in_data_i));
        n_accepted <= n_accepted + 1;
      end
      // Load a new item only when the slot is empty or was just taken;
      // otherwise hold valid and payload as they are.
      if (!in_valid_i || in_ready_o) begin
        if (op_queue.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
          in_valid_i <= 1'b1;
          in_data_i  <= op_queue.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off early in the run, during a no-idle phase, so the
  // sender keeps pushing and the ALU pipeline backs up into in_ready_o.
  always @(posedge clk_i) begin
    if (!hold_done && n_accepted >= HoldAt) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: check each result transaction against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (result_queue.size() == 0) begin
          $error("unexpected result transaction %h", out_data_o);
          n_errors = n_errors + 1;
        end else begin
          expected_item = result_queue.pop_front();
          if (out_data_o.result !== expected_item.result) begin
            $error("result: expected %h, got %h", expected_item.result, out_data_o.result);
            n_errors = n_errors + 1;
          end
          if (out_data_o.result_high !== expected_item.result_high) begin
            $error("result_high: expected %h, got %h", expected_item.result_high,
                   out_data_o.result_high);
            n_errors = n_errors + 1;
          end
          if (out_data_o.flags_out !== expected_item.flags_out) begin
            $error("flags_out: expected %h, got %h", expected_item.flags_out,
                   out_data_o.flags_out);
            n_errors = n_errors + 1;
          end
          if (out_data_o.condition_true !== expected_item.condition_true) begin
            $error("condition_true: expected %b, got %b", expected_item.condition_true,
                   out_data_o.condition_true);
            n_errors = n_errors + 1;
          end
        end
      end
      out_ready_i <= (hold_left == 0) && ($urandom_range(99) >= idle_pct(1'b1));
    end
  end

  // Watchdog: drop the run if it never drains.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count = cycle_count + 1;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int unsigned i;
    logic [4:0]  op;
    logic [31:0] a, b;

    // Directed corner cases: carry and zero, carry-in, overflow, borrow,
    // compare, logic ops, shift amounts 0 and 31, rotates, swaps, both
    // multiply sizes at their extremes, flag load and read, cond, unused op.
    push_op(cpualu_pkg::OP_ADD, 32'hFFFF_FFFF, 32'h0000_0001, cpualu_pkg::COND_EQ);
    push_op(cpualu_pkg::OP_ADC, 32'h0000_0001, 32'hFFFF_FFFE, cpualu_pkg::COND_UGE);
    push_op(cpualu_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h0000_0001, cpualu_pkg::COND_GT);
    push_op(cpualu_pkg::OP_SUB, 32'h0000_0000, 32'h0000_0001, cpualu_pkg::COND_ULT);
    push_op(cpualu_pkg::OP_SBC, 32'h8000_0000, 32'h0000_0000, cpualu_pkg::COND_LT);
    push_op(cpualu_pkg::OP_CMP, 32'h0000_0005, 32'h0000_0005, cpualu_pkg::COND_EQ);
    push_op(cpualu_pkg::OP_CMP, 32'h8000_0000, 32'h0000_0001, cpualu_pkg::COND_GE);
    push_op(cpualu_pkg::OP_AND, 32'hFFFF_FFFF, 32'h0000_0000, cpualu_pkg::COND_LE);
    push_op(cpualu_pkg::OP_OR,  32'hA5A5_A5A5, 32'h5A5A_5A5A, cpualu_pkg::COND_UGT);
    push_op(cpualu_pkg::OP_XOR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, cpualu_pkg::COND_ULE);
    push_op(cpualu_pkg::OP_NOT, 32'h0000_0000, 32'h0000_0000, cpualu_pkg::COND_NE);
    push_op(cpualu_pkg::OP_SRL, 32'h8000_0000, 32'h0000_001F, COND_ALWAYS_LO);
    push_op(cpualu_pkg::OP_SL,  32'h0000_0001, 32'hFFFF_FFFF, COND_ALWAYS_HI);
    push_op(cpualu_pkg::OP_SRA, 32'h8000_0000, 32'h0000_001F, cpualu_pkg::COND_LT);
    push_op(cpualu_pkg::OP_SRA, 32'h8000_0000, 32'hFFFF_FFE0, cpualu_pkg::COND_GE);
    push_op(cpualu_pkg::OP_RR,  32'h1234_5678, 32'h0000_0000, cpualu_pkg::COND_NE);
    push_op(cpualu_pkg::OP_RL,  32'h8000_0001, 32'h0000_001F, cpualu_pkg::COND_EQ);
    push_op(cpualu_pkg::OP_SWAP,  32'h0000_0000, 32'h1122_3344, COND_ALWAYS_LO);
    push_op(cpualu_pkg::OP_SWAPH, 32'hFFFF_FFFF, 32'h1122_3344, COND_ALWAYS_HI);
    push_op(cpualu_pkg::OP_MLTH,  32'hFFFF_8000, 32'h1234_8000, cpualu_pkg::COND_GT);
    push_op(cpualu_pkg::OP_MLTUH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, cpualu_pkg::COND_UGT);
    push_op(cpualu_pkg::OP_MLTW,  32'h8000_0000, 32'hFFFF_FFFF, cpualu_pkg::COND_ULE);
    push_op(cpualu_pkg::OP_MLTUW, 32'hFFFF_FFFF, 32'hFFFF_FFFF, cpualu_pkg::COND_UGE);
    push_op(cpualu_pkg::OP_SETFLAGS, 32'hFFFF_FFFF, 32'h0000_0000, cpualu_pkg::COND_LE);
    push_op(cpualu_pkg::OP_COND,     32'h0000_0000, 32'hFFFF_FFFF, cpualu_pkg::COND_ULT);
    push_op(cpualu_pkg::OP_GETFLAGS, 32'hFFFF_FFF0, 32'h0000_0000, cpualu_pkg::COND_GT);
    push_op(OP_UNUSED_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, COND_ALWAYS_HI);

    // Random traffic: mostly defined ops with biased operands, some unused
    // codes, and equal operands now and then to hit zero on compare.
    for (i = 0; i < RandomOps; i++) begin
      if ($urandom_range(99) < 6) begin
        op = 5'($urandom_range(OP_UNUSED_MAX, OP_UNUSED_MIN));
      end else begin
        op = 5'($urandom_range(cpualu_pkg::OP_GETFLAGS, cpualu_pkg::OP_ADD));
      end
      a = pick_operand();
      b = ($urandom_range(9) == 0) ? a : pick_operand();
      push_op(op, a, b, 4'($urandom_range(15)));
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every queued op to be taken and every result to come back.
    while (op_queue.size() != 0 || in_valid_i || result_queue.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainWait) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
